FILE: rtl/b64e_pkg.sv
// shared types, constants and the character table of the base64 encoder
// no dependencies
package b64e_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam int         QDEPTH   = 2;
	localparam int         QPTR_W   = $clog2(QDEPTH);
	localparam int         QCNT_W   = $clog2(QDEPTH + 1);

	// group of up to three bytes; nbytes counts the real ones (1..3)
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] nbytes;
		logic       last;
	} group_t;

	function automatic logic [7:0] b64e_char(input logic [5:0] v);
		logic [7:0] ch;
		case (v) inside
			[6'd0:6'd25]:  ch = 8'd65 + {2'b00, v};
			[6'd26:6'd51]: ch = 8'd71 + {2'b00, v};
			[6'd52:6'd61]: ch = {2'b00, v} - 8'd4;
			6'd62:         ch = 8'h2B;
			default:       ch = 8'h2F;
		endcase
		return ch;
	endfunction

endpackage

FILE: rtl/b64e_if.sv
// valid/ready stream interfaces for raw bytes and encoded characters
// no dependencies
interface b64e_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

FILE: rtl/b64e_front.sv
// front end: collects bytes into groups of three and pushes each complete group, or a shorter one at end of message
// depends on b64e_pkg and b64e_if
module b64e_front (
	input  logic            clk,
	input  logic            arst_n,
	b64e_in_if.sink         bytes,
	output b64e_pkg::group_t push_data,
	output logic            push_valid,
	input  logic            push_ready
);
	import b64e_pkg::*;

	logic [7:0] held_q [2];
	logic [1:0] count_q;
	logic       take;
	logic       full_grp;
	group_t     grp;

	assign bytes.ready = push_ready;
	assign take        = bytes.valid & push_ready;
	assign full_grp    = count_q[1];

	always_comb begin
		grp = '0;
		if (full_grp) begin
			grp.b0     = held_q[0];
			grp.b1     = held_q[1];
			grp.b2     = bytes.data_byte;
			grp.nbytes = 2'd3;
			grp.last   = bytes.end_of_message;
		end else if (count_q[0]) begin
			grp.b0     = held_q[0];
			grp.b1     = bytes.data_byte;
			grp.nbytes = 2'd2;
			grp.last   = 1'b1;
		end else begin
			grp.b0     = bytes.data_byte;
			grp.nbytes = 2'd1;
			grp.last   = 1'b1;
		end
	end

	assign push_data  = grp;
	assign push_valid = take & (full_grp | bytes.end_of_message);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (take) begin
			if (full_grp | bytes.end_of_message) begin
				count_q <= 2'd0;
			end else begin
				count_q <= count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !full_grp) begin
			held_q[count_q[0]] <= bytes.data_byte;
		end
	end

endmodule

FILE: rtl/b64e_queue.sv
// short queue of groups between front and back end
// depends on b64e_pkg
module b64e_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  b64e_pkg::group_t push_data,
	input  logic             push_valid,
	output logic             push_ready,
	output b64e_pkg::group_t pop_data,
	output logic             pop_valid,
	input  logic             pop_ready
);
	import b64e_pkg::*;

	group_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/b64e_back.sv
// back end: turns one group into four characters, one character per cycle while chars.ready does not stall it
// depends on b64e_pkg and b64e_if
module b64e_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64e_pkg::group_t pop_data,
	input  logic             pop_valid,
	output logic             pop_ready,
	b64e_out_if.source       chars
);
	import b64e_pkg::*;

	group_t     grp_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       out_valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       advance;
	logic [5:0] sext;
	logic [7:0] code;

	assign advance   = !out_valid_q | chars.ready;
	assign pop_ready = !busy_q | (advance & (idx_q == 2'd3));

	always_comb begin
		case (idx_q)
			2'd0:    sext = grp_q.b0[7:2];
			2'd1:    sext = {grp_q.b0[1:0], grp_q.b1[7:4]};
			2'd2:    sext = {grp_q.b1[3:0], grp_q.b2[7:6]};
			default: sext = grp_q.b2[5:0];
		endcase
		code = (idx_q > grp_q.nbytes) ? PAD_CHAR : b64e_char(sext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (advance && busy_q) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			grp_q <= pop_data;
		end
		if (advance && busy_q) begin
			char_q <= code;
			last_q <= (idx_q == 2'd3) & grp_q.last;
		end
	end

	assign chars.valid     = out_valid_q;
	assign chars.char_code = char_q;
	assign chars.last_char = last_q;

endmodule

FILE: rtl/base64_encoder_top.sv
// base64 encoder: one byte per input word, four characters per group of three
// path: a group's closing byte is written into the queue, then popped into the back
// end's group register, and each character is registered before it is output
// throughput: one byte per cycle into a 2-group queue while it has room, one character
// per cycle out while chars.ready is high; the single character output sets the rate
// reset: arst_n clears held count, queue and output valid; no flush pass
// depends on b64e_pkg, b64e_if, b64e_front, b64e_queue, b64e_back
module base64_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	b64e_in_if.sink     bytes,
	b64e_out_if.source  chars
);
	import b64e_pkg::*;

	group_t    push_data;
	logic      push_valid;
	logic      push_ready;
	group_t    pop_data;
	logic      pop_valid;
	logic      pop_ready;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	b64e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.chars     (chars)
	);

endmodule
